// ----- rtl/b64d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, character codes and the sextet lookup for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	typedef struct packed {
		logic       start_of_text;
		logic [7:0] char_code;
	} char_item_t;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic        has_byte;
		logic [1:0]  status;
		logic [15:0] byte_count;
		logic        last_of_run;
	} res_item_t;

	// all results caused by one character
	typedef struct packed {
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [7:0]  byte2;
		logic [1:0]  nbytes;
		logic [1:0]  status;
		logic [15:0] base_count;
	} bundle_t;

	localparam logic [2:0] PH_FIRST    = 3'd0;
	localparam logic [2:0] PH_PLUS     = 3'd1;
	localparam logic [2:0] PH_PREFIXED = 3'd2;
	localparam logic [2:0] PH_QUAD     = 3'd3;
	localparam logic [2:0] PH_DONE     = 3'd4;

	localparam logic [1:0] ST_GO       = 2'd0;
	localparam logic [1:0] ST_FINISHED = 2'd1;
	localparam logic [1:0] ST_ERROR    = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PAD   = 8'h3D;

	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;

	// bit 6 set marks a character outside the alphabet
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] d;
		logic [6:0] r;
		d = 8'd0;
		r = 7'h7F;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
			r = {1'b0, d[5:0]};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h61 + 8'd26;
			r = {1'b0, d[5:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30 + 8'd52;
			r = {1'b0, d[5:0]};
		end else if (c == CH_PLUS) begin
			r = {1'b0, SEXTET_PLUS};
		end else if (c == CH_SLASH) begin
			r = {1'b0, SEXTET_SLASH};
		end
		return r;
	endfunction

endpackage

// ----- rtl/b64d_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_core
// Decode state and per-character logic: builds the result bundle of one item.
// ----------------------------------------------------------------------------
module b64d_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  b64d_pkg::char_item_t  item,
	output logic                  push,
	output b64d_pkg::bundle_t     bundle
);

	logic [2:0]  phase_q;
	logic [1:0]  qpos_q;
	logic [17:0] held_q;
	logic        tpad_q;
	logic [15:0] count_q;

	logic [2:0]  ph, nx_phase;
	logic [1:0]  qp, nx_qp, tk_qp;
	logic [17:0] hs, nx_hs, tk_hs;
	logic        tp, nx_tp;
	logic [15:0] cnt, nx_cnt;
	logic [1:0]  st, nb;
	logic [7:0]  b0, b1, b2, c;
	logic        do_take, bad, pad;
	logic [6:0]  sx;
	logic [5:0]  v;
	logic [16:0] sum;

	always_comb begin
		c   = item.char_code;
		ph  = item.start_of_text ? b64d_pkg::PH_FIRST : phase_q;
		qp  = item.start_of_text ? 2'd0 : qpos_q;
		hs  = item.start_of_text ? 18'd0 : held_q;
		tp  = item.start_of_text ? 1'b0 : tpad_q;
		cnt = item.start_of_text ? 16'd0 : count_q;

		nx_phase = ph;
		nx_qp    = qp;
		nx_hs    = hs;
		nx_tp    = tp;
		st       = b64d_pkg::ST_GO;
		nb       = 2'd0;
		b0       = 8'd0;
		b1       = 8'd0;
		b2       = 8'd0;
		do_take  = 1'b0;
		tk_qp    = qp;
		tk_hs    = hs;

		case (ph)
			b64d_pkg::PH_FIRST: begin
				if (c == b64d_pkg::CH_PLUS) begin
					nx_phase = b64d_pkg::PH_PLUS;
				end else if (c == b64d_pkg::CH_CR) begin
					st = b64d_pkg::ST_FINISHED;
				end else begin
					nx_phase = b64d_pkg::PH_QUAD;
					do_take  = 1'b1;
				end
			end
			b64d_pkg::PH_PLUS: begin
				if (c == b64d_pkg::CH_SPACE) begin
					nx_phase = b64d_pkg::PH_PREFIXED;
				end else begin
					nx_phase = b64d_pkg::PH_QUAD;
					tk_qp    = 2'd1;
					tk_hs    = {12'd0, b64d_pkg::SEXTET_PLUS};
					do_take  = 1'b1;
				end
			end
			b64d_pkg::PH_PREFIXED: begin
				if (c == b64d_pkg::CH_CR) begin
					st = b64d_pkg::ST_FINISHED;
				end else begin
					nx_phase = b64d_pkg::PH_QUAD;
					do_take  = 1'b1;
				end
			end
			b64d_pkg::PH_QUAD: begin
				if (qp == 2'd0 && (c == b64d_pkg::CH_NUL || c == b64d_pkg::CH_CR)) begin
					st = b64d_pkg::ST_FINISHED;
				end else begin
					do_take = 1'b1;
				end
			end
			default: begin
			end
		endcase

		sx  = b64d_pkg::sextet_of(c);
		bad = sx[6];
		v   = sx[5:0];
		pad = (c == b64d_pkg::CH_PAD);

		if (do_take) begin
			nx_qp = tk_qp;
			nx_hs = tk_hs;
			case (tk_qp)
				2'd0, 2'd1: begin
					if (bad) begin
						st = b64d_pkg::ST_ERROR;
					end else begin
						nx_hs = {tk_hs[11:0], v};
						nx_qp = tk_qp + 2'd1;
					end
				end
				2'd2: begin
					if (pad) begin
						nx_tp = 1'b1;
						nx_hs = {tk_hs[11:0], 6'd0};
						nx_qp = 2'd3;
					end else if (bad) begin
						st = b64d_pkg::ST_ERROR;
					end else begin
						nx_hs = {tk_hs[11:0], v};
						nx_qp = 2'd3;
					end
				end
				default: begin
					if (!pad && bad) begin
						st = b64d_pkg::ST_ERROR;
					end else begin
						b0    = {tk_hs[17:12], tk_hs[11:10]};
						b1    = {tk_hs[9:6], tk_hs[5:2]};
						b2    = {tk_hs[1:0], v};
						nb    = tp ? 2'd1 : (pad ? 2'd2 : 2'd3);
						nx_qp = 2'd0;
						nx_hs = 18'd0;
						nx_tp = 1'b0;
						st    = pad ? b64d_pkg::ST_FINISHED : b64d_pkg::ST_GO;
					end
				end
			endcase
		end

		if (st != b64d_pkg::ST_GO) begin
			nx_phase = b64d_pkg::PH_DONE;
		end

		sum    = {1'b0, cnt} + {15'd0, nb};
		nx_cnt = sum[16] ? 16'hFFFF : sum[15:0];
	end

	assign push              = take && (ph != b64d_pkg::PH_DONE);
	assign bundle.byte0      = b0;
	assign bundle.byte1      = b1;
	assign bundle.byte2      = b2;
	assign bundle.nbytes     = nb;
	assign bundle.status     = st;
	assign bundle.base_count = cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64d_pkg::PH_FIRST;
			qpos_q  <= 2'd0;
			held_q  <= 18'd0;
			tpad_q  <= 1'b0;
			count_q <= 16'd0;
		end else if (take) begin
			phase_q <= nx_phase;
			qpos_q  <= nx_qp;
			held_q  <= nx_hs;
			tpad_q  <= nx_tp;
			count_q <= nx_cnt;
		end
	end

endmodule

// ----- rtl/base64_stream_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 text decoder, one character per item.
// ----------------------------------------------------------------------------
// Usage:
//   char channel (char_valid / char_stall / char_item) carries one character
//   and a start_of_text flag; start_of_text clears all decode state.
//   res channel (res_valid / res_stall / res_item) carries results: one
//   result with no byte, or one result per decoded byte (up to three),
//   last_of_run marking the final result of a character.
//   Items after a finish or an error give no result until start_of_text.
// Timing:
//   The results of a character are written into the result queue when it
//   is accepted. A character is accepted every cycle while the two-entry
//   result queue is not full; a quartet's fourth character gives up to
//   three results, which leave the queue one at a time.
//   char_stall is high only while the queue is full.
// Reset:
//   arst_n empties the queue and returns the decoder to the start of text.
// Stall:
//   While res_stall is high the current result holds; the queue keeps
//   taking characters until both entries are full.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  b64d_pkg::char_item_t  char_item,
	output logic                  res_valid,
	input  logic                  res_stall,
	output b64d_pkg::res_item_t   res_item
);

	logic              accept, push, pop, pop_last;
	b64d_pkg::bundle_t bundle;
	b64d_pkg::bundle_t ent_q [2];
	b64d_pkg::bundle_t head;
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        cnt_q, idx_q;
	logic              has, last;
	logic [16:0]       osum;
	logic [7:0]        obyte;

	assign accept = char_valid && !char_stall;

	b64d_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (accept),
		.item   (char_item),
		.push   (push),
		.bundle (bundle)
	);

	assign char_stall = (cnt_q == 2'd2);
	assign res_valid  = (cnt_q != 2'd0);
	assign head       = ent_q[rd_ptr_q];
	assign has        = (head.nbytes != 2'd0);
	assign last       = !has || (idx_q == head.nbytes - 2'd1);
	assign pop        = res_valid && !res_stall;
	assign pop_last   = pop && last;

	always_comb begin
		case (idx_q)
			2'd0:    obyte = head.byte0;
			2'd1:    obyte = head.byte1;
			default: obyte = head.byte2;
		endcase
		osum = {1'b0, head.base_count} + {15'd0, idx_q} + 17'd1;
	end

	assign res_item.byte_value  = has ? obyte : 8'd0;
	assign res_item.has_byte    = has;
	assign res_item.status      = head.status;
	assign res_item.byte_count  = !has ? head.base_count : (osum[16] ? 16'hFFFF : osum[15:0]);
	assign res_item.last_of_run = last;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
			idx_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop_last) begin
				rd_ptr_q <= !rd_ptr_q;
				idx_q    <= 2'd0;
			end else if (pop) begin
				idx_q <= idx_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_last};
		end
	end

`ifndef ASSERT_OFF
	a_nobyte_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.has_byte |-> res_item.last_of_run)
		else $error("result without byte not last of run");

	a_error_nobyte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.status == b64d_pkg::ST_ERROR |-> !res_item.has_byte)
		else $error("error result carries a byte");

	a_midrun_go: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.last_of_run |->
			res_item.has_byte && res_item.status != b64d_pkg::ST_ERROR)
		else $error("bad mid-run result");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |=> !push || $past(pop_last))
		else $error("result queue overrun");
`endif

endmodule

// ----- bench/tb_base64_stream_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder
// Self-checking bench for the base64 stream decoder. Characters go in on the
// char channel. A class tracks the decode state and queues the bytes and
// status it expects. Each result is checked against that queue. Stimulus is a
// short directed run, a long hold on the result side, then random strings
// (prefixes, pads, terminators, noise), with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_ITEMS = 70;

	class b64_byte_tracker;
		logic [2:0]            phase;
		logic [1:0]            qpos;
		logic [17:0]           held;
		logic                  third_pad;
		logic [15:0]           count;
		logic [7:0]            out_b [3];
		int                    nb;
		b64d_pkg::res_item_t   due_bytes [$];
		int                    mismatches;

		function new();
			restart();
			mismatches = 0;
		endfunction

		function void restart();
			phase = b64d_pkg::PH_FIRST;
			qpos = 2'd0;
			held = 18'd0;
			third_pad = 1'b0;
			count = 16'd0;
		endfunction

		function logic [6:0] sextet_value(input logic [7:0] c);
			if (c >= "A" && c <= "Z") return {1'b0, 6'(c - 8'h41)};
			if (c >= "a" && c <= "z") return {1'b0, 6'(c - 8'h61 + 8'd26)};
			if (c >= "0" && c <= "9") return {1'b0, 6'(c - 8'h30 + 8'd52)};
			if (c == b64d_pkg::CH_PLUS) return {1'b0, b64d_pkg::SEXTET_PLUS};
			if (c == b64d_pkg::CH_SLASH) return {1'b0, b64d_pkg::SEXTET_SLASH};
			return 7'h40;
		endfunction

		function logic [1:0] take_quartet_char(input logic [7:0] c);
			logic [6:0] v;
			logic       is_pad;
			logic [5:0] s1, s2, s3;
			v = sextet_value(c);
			is_pad = (c == b64d_pkg::CH_PAD);
			nb = 0;
			if (qpos < 2'd2) begin
				if (v[6]) return b64d_pkg::ST_ERROR;
				held = {held[11:0], v[5:0]};
				qpos = qpos + 2'd1;
				return b64d_pkg::ST_GO;
			end
			if (qpos == 2'd2) begin
				if (is_pad) begin
					third_pad = 1'b1;
					held = {held[11:0], 6'd0};
				end else begin
					if (v[6]) return b64d_pkg::ST_ERROR;
					held = {held[11:0], v[5:0]};
				end
				qpos = 2'd3;
				return b64d_pkg::ST_GO;
			end
			if (!is_pad && v[6]) return b64d_pkg::ST_ERROR;
			s1 = held[17:12];
			s2 = held[11:6];
			s3 = held[5:0];
			out_b[0] = {s1, s2[5:4]};
			nb = 1;
			if (!third_pad) begin
				out_b[1] = {s2[3:0], s3[5:2]};
				nb = 2;
				if (!is_pad) begin
					out_b[2] = {s3[1:0], v[5:0]};
					nb = 3;
				end
			end
			qpos = 2'd0;
			held = 18'd0;
			third_pad = 1'b0;
			return is_pad ? b64d_pkg::ST_FINISHED : b64d_pkg::ST_GO;
		endfunction

		// returns the number of results this character causes
		function int note_char(input b64d_pkg::char_item_t it);
			logic [7:0]          c;
			logic [1:0]          st;
			int                  n;
			b64d_pkg::res_item_t r;
			c = it.char_code;
			st = b64d_pkg::ST_GO;
			nb = 0;
			if (it.start_of_text) restart();
			if (phase == b64d_pkg::PH_DONE) return 0;
			case (phase)
				b64d_pkg::PH_FIRST: begin
					if (c == b64d_pkg::CH_PLUS) phase = b64d_pkg::PH_PLUS;
					else if (c == b64d_pkg::CH_CR) st = b64d_pkg::ST_FINISHED;
					else begin
						phase = b64d_pkg::PH_QUAD;
						st = take_quartet_char(c);
					end
				end
				b64d_pkg::PH_PLUS: begin
					if (c == b64d_pkg::CH_SPACE) phase = b64d_pkg::PH_PREFIXED;
					else begin
						phase = b64d_pkg::PH_QUAD;
						held = {12'd0, b64d_pkg::SEXTET_PLUS};
						qpos = 2'd1;
						st = take_quartet_char(c);
					end
				end
				b64d_pkg::PH_PREFIXED: begin
					if (c == b64d_pkg::CH_CR) st = b64d_pkg::ST_FINISHED;
					else begin
						phase = b64d_pkg::PH_QUAD;
						st = take_quartet_char(c);
					end
				end
				default: begin
					if (qpos == 2'd0 && (c == b64d_pkg::CH_NUL || c == b64d_pkg::CH_CR))
						st = b64d_pkg::ST_FINISHED;
					else st = take_quartet_char(c);
				end
			endcase
			if (st != b64d_pkg::ST_GO) phase = b64d_pkg::PH_DONE;
			n = (nb > 0) ? nb : 1;
			for (int k = 0; k < n; k++) begin
				if (nb > 0) begin
					if (count != 16'hFFFF) count = count + 16'd1;
					r.byte_value = out_b[k];
					r.has_byte = 1'b1;
				end else begin
					r.byte_value = 8'd0;
					r.has_byte = 1'b0;
				end
				r.status = st;
				r.byte_count = count;
				r.last_of_run = (k == n - 1);
				due_bytes.push_back(r);
			end
			return n;
		endfunction

		function void check_result(input b64d_pkg::res_item_t got);
			b64d_pkg::res_item_t want;
			if (due_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: byte=%02h has=%0d st=%0d cnt=%0d last=%0d",
						got.byte_value, got.has_byte, got.status, got.byte_count,
						got.last_of_run);
				return;
			end
			want = due_bytes.pop_front();
			if (got.byte_value !== want.byte_value || got.has_byte !== want.has_byte ||
					got.status !== want.status || got.byte_count !== want.byte_count ||
					got.last_of_run !== want.last_of_run) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp byte=%02h has=%0d st=%0d cnt=%0d last=%0d",
						want.byte_value, want.has_byte, want.status, want.byte_count,
						want.last_of_run);
					$display("          got byte=%02h has=%0d st=%0d cnt=%0d last=%0d",
						got.byte_value, got.has_byte, got.status, got.byte_count,
						got.last_of_run);
				end
			end
		endfunction

		function int pending();
			return due_bytes.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 char_valid = 1'b0;
	logic                 char_stall;
	b64d_pkg::char_item_t char_item = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	b64d_pkg::res_item_t  res_item;

	b64_byte_tracker tracker;
	int unsigned     cycles = 0;
	int              hold_len = 0;
	bit              rx_hold = 1'b0;
	int              rx_wait = 0;
	bit              rx_calm = 1'b0;
	bit              tx_calm = 1'b0;
	int              live_items = 0;

	base64_stream_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// hold the result side once a hold is requested; hold_len sets its length
	initial begin
		wait (hold_len > 0);
		rx_hold <= 1'b1;
		repeat (hold_len) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// result side: check, then draw the wait before the next result
	always @(posedge clk) begin
		if (res_valid && !res_stall) begin
			tracker.check_result(res_item);
			rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
		end
		if (rx_hold) begin
			res_stall <= 1'b1;
		end else if (rx_wait > 0) begin
			res_stall <= 1'b1;
			rx_wait--;
		end else begin
			res_stall <= 1'b0;
		end
	end

	function automatic logic [7:0] alpha_char(input logic [5:0] idx);
		if (idx < 6'd26) return 8'h41 + {2'b00, idx};
		if (idx < 6'd52) return 8'h61 + {2'b00, idx} - 8'd26;
		if (idx < 6'd62) return 8'h30 + {2'b00, idx} - 8'd52;
		if (idx == 6'd62) return b64d_pkg::CH_PLUS;
		return b64d_pkg::CH_SLASH;
	endfunction

	task automatic send_char(input logic sot, input logic [7:0] c);
		int                   gap;
		b64d_pkg::char_item_t it;
		gap = tx_calm ? 0 : $urandom_range(0, 7);
		it.start_of_text = sot;
		it.char_code = c;
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_item <= it;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		if (tracker.note_char(it) > 0) live_items++;
	endtask

	task automatic send_text(input string s, input bit sot_first);
		for (int i = 0; i < s.len(); i++)
			send_char(sot_first && i == 0, s[i]);
	endtask

	task automatic wait_drained();
		while (tracker.pending() > 0) @(posedge clk);
	endtask

	task automatic random_string();
		logic [7:0] txt [$];
		int         nq;
		int         pick;
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			txt.push_back(b64d_pkg::CH_PLUS);
			txt.push_back(b64d_pkg::CH_SPACE);
		end else if (pick == 3) begin
			txt.push_back(b64d_pkg::CH_PLUS);
		end
		nq = $urandom_range(0, 4);
		for (int k = 0; k < nq * 4; k++)
			txt.push_back(alpha_char(6'($urandom_range(0, 63))));
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			txt.push_back(b64d_pkg::CH_NUL);
		end else if (pick < 5) begin
			txt.push_back(b64d_pkg::CH_CR);
		end else if (pick == 5) begin
			txt.push_back(alpha_char(6'($urandom_range(0, 63))));
			txt.push_back(alpha_char(6'($urandom_range(0, 63))));
			txt.push_back(b64d_pkg::CH_PAD);
			txt.push_back(b64d_pkg::CH_PAD);
		end else if (pick == 6) begin
			repeat (3) txt.push_back(alpha_char(6'($urandom_range(0, 63))));
			txt.push_back(b64d_pkg::CH_PAD);
		end else if (pick == 7) begin
			txt.push_back(alpha_char(6'($urandom_range(0, 63))));
			txt.push_back(alpha_char(6'($urandom_range(0, 63))));
			txt.push_back(b64d_pkg::CH_PAD);
			txt.push_back(alpha_char(6'($urandom_range(0, 63))));
			txt.push_back(b64d_pkg::CH_NUL);
		end
		// corrupt one character now and then
		if (txt.size() > 0 && $urandom_range(0, 3) == 0)
			txt[$urandom_range(0, txt.size() - 1)] =
				($urandom_range(0, 2) == 0) ? b64d_pkg::CH_PAD : 8'($urandom_range(0, 255));
		if ($urandom_range(0, 4) == 0) txt.push_back(8'($urandom_range(0, 255)));
		tx_calm = ($urandom_range(0, 3) == 0);
		rx_calm = ($urandom_range(0, 3) == 0);
		for (int k = 0; k < txt.size(); k++)
			send_char(k == 0, txt[k]);
	endtask

	initial begin
		tracker = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no start flag after reset, prefix, all-ones and all-zero content
		send_text("+ ////", 1'b0);
		send_text("AB=/", 1'b0);
		send_text("TQ==", 1'b0);
		send_char(1'b0, "Z");
		send_char(1'b1, b64d_pkg::CH_CR);
		send_text("+ ", 1'b1);
		send_char(1'b0, b64d_pkg::CH_CR);
		send_text("+8==", 1'b1);
		send_char(1'b1, "a");
		send_char(1'b0, b64d_pkg::CH_NUL);
		send_char(1'b1, 8'hFF);
		send_text("AAAA", 1'b1);
		send_char(1'b0, 8'h80);
		send_text("z9+w", 1'b1);
		send_char(1'b0, b64d_pkg::CH_NUL);

		// hold the result side while characters keep coming
		wait_drained();
		tx_calm = 1'b1;
		hold_len = 60;
		send_text("TWFueSBoYW5kcw==", 1'b1);
		tx_calm = 1'b0;

		live_items = 0;
		while (live_items < RANDOM_ITEMS) random_string();

		wait_drained();
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		send_text("QUJD", 1'b1);
		send_char(1'b0, b64d_pkg::CH_CR);

		char_valid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/b64d_pkg.sv
rtl/b64d_core.sv
rtl/base64_stream_decoder.sv
bench/tb_base64_stream_decoder.sv
